// ===== hw/rtl/spc_pkg.sv =====
// Shared types and constants for the spectral pixel correlation block.
// Used by every module under hw/rtl except spc_ram; depends on nothing.
package spc_pkg;

    localparam int W_BAND    = 8;
    localparam int W_SAMPLE  = 16;
    localparam int W_COEF    = 18;
    localparam int W_ACC     = 44;
    localparam int W_SPAN    = 16;
    localparam int W_CFG_IDX = 1;

    localparam int MAX_BANDS_DEF   = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    // pending pixel jobs between the accumulate side and the divide side
    localparam int Q_DEPTH = 4;
    localparam int W_QPTR  = $clog2(Q_DEPTH);
    localparam int W_QCNT  = $clog2(Q_DEPTH + 1);

    localparam logic [W_SAMPLE-1:0]     PIXEL_SEED_RST = 16'd10000;
    localparam logic signed [W_ACC-1:0] FRAME_SEED_RST = 44'sd163840000;

    localparam logic signed [W_ACC-1:0] ACC_MAX = {1'b0, {(W_ACC-1){1'b1}}};
    localparam logic signed [W_ACC-1:0] ACC_MIN = {1'b1, {(W_ACC-1){1'b0}}};

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [W_CFG_IDX-1:0] CFG_PIXEL_MIN_SEED = 1'b0;
    localparam logic [W_CFG_IDX-1:0] CFG_FRAME_MIN_SEED = 1'b1;

    // one finished pixel, waiting for its division
    typedef struct packed {
        logic signed [W_ACC-1:0] sum;
        logic [W_SPAN-1:0]       span;
        logic                    zero;
        logic                    fs;
        logic signed [W_ACC-1:0] fseed;
    } t_job;

endpackage

// ===== hw/rtl/spectral_pixel_correlation.sv =====
// Loads and band samples: one transfer per cycle while the job queue has room.
// Result: the last band's sum passes the weight-read and accumulate registers into the
// job queue, then the 44-bit restoring divider (one quotient bit a cycle), skipped for a
// zero range, and the output register; samples of later pixels enter meanwhile.
// Synchronous active-low reset clears control, seeds and frame extremes; the
// weight table is not cleared and holds garbage until loaded.
module spectral_pixel_correlation import spc_pkg::*; #(
    parameter int MAX_BANDS   = MAX_BANDS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_action,
    input  logic [W_BAND-1:0]        i_band,
    input  logic [W_SAMPLE-1:0]      i_sample_value,
    input  logic signed [W_COEF-1:0] i_coefficient,
    input  logic                     i_last_band,
    input  logic                     i_frame_start,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [W_ACC-1:0]  o_correlation,
    output logic                     o_range_zero,
    output logic signed [W_ACC-1:0]  o_frame_min,
    output logic signed [W_ACC-1:0]  o_frame_max,
    input  logic                     i_cfg_we,
    input  logic [W_CFG_IDX-1:0]     i_cfg_index,
    input  logic [W_ACC-1:0]         i_cfg_data
);

    logic [W_SAMPLE-1:0]     r_pixel_seed;
    logic signed [W_ACC-1:0] r_frame_seed;
    logic                    push, pop, q_valid;
    t_job                    push_job, head;
    logic [W_QCNT-1:0]       q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_seed <= PIXEL_SEED_RST;
            r_frame_seed <= FRAME_SEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PIXEL_MIN_SEED: r_pixel_seed <= i_cfg_data[W_SAMPLE-1:0];
                CFG_FRAME_MIN_SEED: r_frame_seed <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    spc_front #(
        .MAX_BANDS   (MAX_BANDS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_band         (i_band),
        .i_sample_value (i_sample_value),
        .i_coefficient  (i_coefficient),
        .i_last_band    (i_last_band),
        .i_frame_start  (i_frame_start),
        .i_pixel_seed   (r_pixel_seed),
        .i_frame_seed   (r_frame_seed),
        .i_q_count      (q_count),
        .o_push         (push),
        .o_job          (push_job)
    );

    spc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_job       (push_job),
        .i_pop       (pop),
        .o_not_empty (q_valid),
        .o_head      (head),
        .o_count     (q_count)
    );

    spc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_correlation (o_correlation),
        .o_range_zero  (o_range_zero),
        .o_frame_min   (o_frame_min),
        .o_frame_max   (o_frame_max)
    );

endmodule

// ===== hw/rtl/spc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/spc_front.sv =====
// Front side: accepts loads and samples, holds the weight table, tracks the
// pixel extremes and accumulates the weighted sum. Depends on spc_pkg, spc_ram.
module spc_front import spc_pkg::*; #(
    parameter int MAX_BANDS   = MAX_BANDS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_action,
    input  logic [W_BAND-1:0]       i_band,
    input  logic [W_SAMPLE-1:0]     i_sample_value,
    input  logic signed [W_COEF-1:0] i_coefficient,
    input  logic                    i_last_band,
    input  logic                    i_frame_start,
    input  logic [W_SAMPLE-1:0]     i_pixel_seed,
    input  logic signed [W_ACC-1:0] i_frame_seed,
    input  logic [W_QCNT-1:0]       i_q_count,
    output logic                    o_push,
    output t_job                    o_job
);

    localparam int AW = $clog2(MAX_BANDS);
    localparam int BW = (AW > W_BAND) ? AW : W_BAND;
    localparam int PW = SAMPLE_BITS + 1 + W_COEF;

    logic                  acc;
    logic [BW-1:0]         band_x;
    logic [AW-1:0]         addr;
    logic                  in_range;
    logic [W_SAMPLE-1:0]   smp;
    logic [W_SAMPLE-1:0]   low_eff, high_eff, low_new, high_new;
    logic                  fs_eff;
    logic signed [W_ACC-1:0] seed_eff;
    logic [W_COEF-1:0]     rdata;

    // pixel and frame-restart tracking at the input
    logic                  r_open;
    logic [W_SAMPLE-1:0]   r_low, r_high;
    logic                  r_fs_pend;
    logic signed [W_ACC-1:0] r_fs_seed;

    // stage 1: weight read
    logic                  r_s1_valid, r_s1_first, r_s1_last, r_s1_inr;
    logic [SAMPLE_BITS-1:0] r_s1_sample;
    t_job                  r_s1_job;
    logic signed [W_COEF-1:0] weight;
    logic signed [PW-1:0]  prod;

    // stage 2: accumulate
    logic                  r_s2_valid, r_s2_first, r_s2_last;
    logic signed [PW-1:0]  r_s2_prod;
    t_job                  r_s2_job;
    logic signed [W_ACC-1:0] r_acc;
    logic signed [W_ACC-1:0] acc_base, acc_sat;
    logic signed [W_ACC:0] acc_sum;
    logic [W_QCNT+1:0]     occ;

    // stall while every queue slot may be claimed by pixels already inside
    assign occ = (W_QCNT+2)'(i_q_count) + (W_QCNT+2)'(r_s1_valid & r_s1_last)
               + (W_QCNT+2)'(r_s2_valid & r_s2_last);
    assign o_stall = (occ >= (W_QCNT+2)'(Q_DEPTH));
    assign acc = i_valid & ~o_stall;

    assign band_x   = BW'(i_band);
    assign addr     = band_x[AW-1:0];
    assign in_range = (32'(i_band) < MAX_BANDS);
    assign smp      = W_SAMPLE'(i_sample_value[SAMPLE_BITS-1:0]);

    assign low_eff  = r_open ? r_low : i_pixel_seed;
    assign high_eff = r_open ? r_high : '0;
    assign low_new  = (smp < low_eff) ? smp : low_eff;
    assign high_new = (smp > high_eff) ? smp : high_eff;
    assign fs_eff   = r_fs_pend | i_frame_start;
    assign seed_eff = i_frame_start ? i_frame_seed : r_fs_seed;

    spc_ram #(
        .WIDTH (W_COEF),
        .DEPTH (MAX_BANDS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (acc && i_action == ACT_LOAD && in_range),
        .i_waddr (addr),
        .i_wdata (i_coefficient),
        .i_re    (acc && i_action == ACT_SAMPLE),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_fs_pend  <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc && i_action == ACT_SAMPLE;
            if (acc && i_action == ACT_SAMPLE) begin
                r_open    <= ~i_last_band;
                r_fs_pend <= fs_eff & ~i_last_band;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_action == ACT_SAMPLE) begin
            r_low            <= low_new;
            r_high           <= high_new;
            r_fs_seed        <= seed_eff;
            r_s1_first       <= ~r_open;
            r_s1_last        <= i_last_band;
            r_s1_inr         <= in_range;
            r_s1_sample      <= i_sample_value[SAMPLE_BITS-1:0];
            r_s1_job.sum     <= '0;
            r_s1_job.span    <= high_new - low_new;
            r_s1_job.zero    <= (high_new <= low_new);
            r_s1_job.fs      <= fs_eff;
            r_s1_job.fseed   <= seed_eff;
        end
    end

    assign weight = r_s1_inr ? $signed(rdata) : '0;
    assign prod   = $signed({1'b0, r_s1_sample}) * weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_prod  <= prod;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            r_s2_job   <= r_s1_job;
        end
    end

    // restart the sum on the first sample of a pixel, saturate to 44 bits
    assign acc_base = r_s2_first ? '0 : r_acc;
    assign acc_sum  = (W_ACC+1)'(acc_base) + (W_ACC+1)'(r_s2_prod);
    always_comb begin
        if (acc_sum[W_ACC] != acc_sum[W_ACC-1]) begin
            acc_sat = acc_sum[W_ACC] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_sat = acc_sum[W_ACC-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_s2_valid) begin
            r_acc <= acc_sat;
        end
    end

    assign o_push = r_s2_valid & r_s2_last;
    always_comb begin
        o_job     = r_s2_job;
        o_job.sum = acc_sat;
    end

endmodule

// ===== hw/rtl/spc_queue.sv =====
// Short FIFO of finished pixel jobs between the front and back sides.
// Depends on spc_pkg.
module spc_queue import spc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_job              i_job,
    input  logic              i_pop,
    output logic              o_not_empty,
    output t_job              o_head,
    output logic [W_QCNT-1:0] o_count
);

    t_job              r_slot [Q_DEPTH];
    logic [W_QPTR-1:0] r_wptr, r_rptr;
    logic [W_QCNT-1:0] r_count;
    logic              pop_ok;

    assign pop_ok = i_pop & (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == W_QPTR'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == W_QPTR'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + W_QCNT'(i_push) - W_QCNT'(pop_ok);
        end
    end

    assign o_not_empty = (r_count != '0);
    assign o_head      = r_slot[r_rptr];
    assign o_count     = r_count;

endmodule

// ===== hw/rtl/spc_back.sv =====
// Back side: divides each nonzero-range pixel sum by its range one quotient bit per cycle,
// updates the frame extremes and holds the output register. Depends on spc_pkg.
module spc_back import spc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  t_job                     i_head,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [W_ACC-1:0]  o_correlation,
    output logic                     o_range_zero,
    output logic signed [W_ACC-1:0]  o_frame_min,
    output logic signed [W_ACC-1:0]  o_frame_max
);

    localparam int W_CNT = $clog2(W_ACC);

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_DIV  = 3'b010,
        BK_OUT  = 3'b100
    } t_bk_state;

    t_bk_state               r_state, n_state;
    logic [W_SPAN-1:0]       r_rem, r_div;
    logic [W_ACC-1:0]        r_quo;
    logic [W_CNT-1:0]        r_cnt;
    logic                    r_neg, r_zero, r_fs;
    logic signed [W_ACC-1:0] r_fseed;
    logic signed [W_ACC-1:0] r_frame_low, r_frame_high;
    logic                    r_o_valid;
    logic signed [W_ACC-1:0] r_o_corr, r_o_fmin, r_o_fmax;
    logic                    r_o_zero;

    logic [W_ACC-1:0]        mag;
    logic [W_SPAN:0]         rem_sh, rem_diff;
    logic                    ge;
    logic signed [W_ACC-1:0] corr, fl_base, fh_base, fl_new, fh_new;
    logic                    out_free, commit;

    assign mag      = i_head.sum[W_ACC-1] ? W_ACC'(-i_head.sum) : W_ACC'(i_head.sum);
    assign rem_sh   = {r_rem, r_quo[W_ACC-1]};
    assign rem_diff = rem_sh - {1'b0, r_div};
    assign ge       = (rem_sh >= {1'b0, r_div});

    assign corr    = r_zero ? '0 : (r_neg ? -$signed(r_quo) : $signed(r_quo));
    assign fl_base = r_fs ? r_fseed : r_frame_low;
    assign fh_base = r_fs ? '0 : r_frame_high;
    // a zero-range pixel does not move the extremes, though a frame start still reseeds them
    assign fl_new  = (!r_zero && corr < fl_base) ? corr : fl_base;
    assign fh_new  = (!r_zero && corr > fh_base) ? corr : fh_base;

    assign out_free = ~r_o_valid | ~i_stall;
    assign commit   = (r_state == BK_OUT) & out_free;
    assign o_pop    = (r_state == BK_IDLE) & i_q_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_head.zero ? BK_OUT : BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_cnt == '0) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_o_valid    <= 1'b0;
            r_frame_low  <= FRAME_SEED_RST;
            r_frame_high <= '0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_o_valid    <= 1'b1;
                r_frame_low  <= fl_new;
                r_frame_high <= fh_new;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_quo   <= mag;
            r_rem   <= '0;
            r_div   <= i_head.span;
            r_neg   <= i_head.sum[W_ACC-1];
            r_zero  <= i_head.zero;
            r_fs    <= i_head.fs;
            r_fseed <= i_head.fseed;
            r_cnt   <= W_CNT'(W_ACC - 1);
        end else if (r_state == BK_DIV) begin
            r_rem <= ge ? rem_diff[W_SPAN-1:0] : rem_sh[W_SPAN-1:0];
            r_quo <= {r_quo[W_ACC-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
        if (commit) begin
            r_o_corr <= corr;
            r_o_zero <= r_zero;
            r_o_fmin <= fl_new;
            r_o_fmax <= fh_new;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_correlation = r_o_corr;
    assign o_range_zero  = r_o_zero;
    assign o_frame_min   = r_o_fmin;
    assign o_frame_max   = r_o_fmax;

endmodule

// ===== hw/rtl/spc_checker.sv =====
// Port-level checks for spectral_pixel_correlation, bound to the top level.
// Depends on spc_pkg.
module spc_checker import spc_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic signed [W_ACC-1:0]  o_correlation,
    input logic                     o_range_zero,
    input logic signed [W_ACC-1:0]  o_frame_min,
    input logic signed [W_ACC-1:0]  o_frame_max
);

    // a held result keeps its correlation and frame maximum
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_correlation) && $stable(o_frame_max))
        else $error("result changed while stalled");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_zero |-> o_correlation == '0)
        else $error("zero range with nonzero correlation");

    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_range_zero |-> o_frame_min <= o_correlation && o_frame_max >= o_correlation)
        else $error("correlation outside frame extremes");

    // frame maximum starts at zero, so it never goes negative
    a_fmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_frame_max[W_ACC-1])
        else $error("negative frame maximum");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind spectral_pixel_correlation spc_checker u_spc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_correlation (o_correlation),
    .o_range_zero  (o_range_zero),
    .o_frame_min   (o_frame_min),
    .o_frame_max   (o_frame_max)
);
